// ===== hw/rtl/xdfl_pkg.sv =====
package xdfl_pkg;

  localparam int unsigned MAX_CERT_BYTES = 65536;
  localparam int unsigned POS_W = 17;
  localparam int unsigned ACC_W = 32;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] LEN_LONG_MASK = 8'h80;
  localparam logic [6:0] LEN_CNT_MASK = 7'h7f;
  localparam logic [7:0] VERSION_TAG_MASK = 8'ha0;

  localparam logic [2:0] FID_SERIAL_HDR = 3'd0;
  localparam logic [2:0] FID_SERIAL_VAL = 3'd1;
  localparam logic [2:0] FID_ISSUER = 3'd2;
  localparam logic [2:0] FID_VALIDITY = 3'd3;
  localparam logic [2:0] FID_SUBJECT = 3'd4;
  localparam logic [2:0] FID_KEY = 3'd5;

  typedef enum logic [3:0] {
    ST_OUTER,
    ST_BODY,
    ST_FIRST,
    ST_VERSION,
    ST_SERIAL,
    ST_OID,
    ST_ISSUER,
    ST_VALID,
    ST_SUBJ,
    ST_KEY
  } stage_t;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN1,
    PH_LENX,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [2:0]  field_id;
    logic [15:0] offset;
    logic [16:0] length;
    logic        failed;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/xdfl_core.sv =====
module xdfl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic [16:0]       total_length,
  input  logic              stop_after_issuer,
  output logic              res0_valid,
  output xdfl_pkg::result_t res0,
  output logic              res1_valid,
  output xdfl_pkg::result_t res1
);
  import xdfl_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  stage_t           stage, stage_next;
  phase_t           phase, phase_next;
  logic [6:0]       len_left, len_left_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [15:0]      hdr_start, hdr_start_next;
  logic [POS_W-1:0] content_end, content_end_next;
  logic [POS_W-1:0] outer_end, outer_end_next;
  logic [POS_W-1:0] body_end, body_end_next;
  logic [POS_W-1:0] cert_end, cert_end_next;
  logic             finished, finished_next;

  logic             fail;
  logic [2:0]       fail_id;
  logic             hd;
  logic [17:0]      p_ext, cs, reg_end, room_left, ce, nreg, nxt, full, pos_inc;
  logic [6:0]       cnt;

  function automatic logic [2:0] fail_field(stage_t s);
    logic [2:0] f;
    case (s)
      ST_OUTER, ST_BODY, ST_FIRST, ST_VERSION, ST_SERIAL: f = FID_SERIAL_HDR;
      ST_OID, ST_ISSUER: f = FID_ISSUER;
      ST_VALID: f = FID_VALIDITY;
      ST_SUBJ: f = FID_SUBJECT;
      default: f = FID_KEY;
    endcase
    return f;
  endfunction

  always_comb begin
    pos_next         = pos;
    stage_next       = stage;
    phase_next       = phase;
    len_left_next    = len_left;
    acc_next         = acc;
    hdr_start_next   = hdr_start;
    content_end_next = content_end;
    outer_end_next   = outer_end;
    body_end_next    = body_end;
    cert_end_next    = cert_end;
    finished_next    = finished;
    res0_valid       = 1'b0;
    res1_valid       = 1'b0;
    res0             = '0;
    res1             = '0;
    fail             = 1'b0;
    fail_id          = FID_SERIAL_HDR;
    hd               = 1'b0;
    p_ext            = {1'b0, pos};
    cs               = p_ext + 18'd1;
    cnt              = data_byte[6:0] & LEN_CNT_MASK;
    reg_end          = '0;
    room_left        = '0;
    ce               = '0;
    nreg             = '0;
    nxt              = '0;
    full             = '0;

    if (!finished) begin
      if (pos == '0) begin
        if (total_length > POS_W'(MAX_CERT_BYTES)) cert_end_next = POS_W'(MAX_CERT_BYTES);
        else cert_end_next = total_length;
      end
      if (stage == ST_OUTER) reg_end = {1'b0, cert_end_next};
      else if (stage == ST_BODY) reg_end = {1'b0, outer_end};
      else reg_end = {1'b0, body_end};

      if (pos == '0 && cert_end_next < POS_W'(2)) begin
        fail    = 1'b1;
        fail_id = fail_field(stage);
      end else begin
        case (phase)
          PH_TAG: begin
            hdr_start_next = pos[15:0];
            if (data_byte == 8'd0) begin
              fail    = 1'b1;
              fail_id = fail_field(stage);
            end else begin
              if (stage == ST_FIRST) begin
                if ((data_byte & VERSION_TAG_MASK) == VERSION_TAG_MASK) stage_next = ST_VERSION;
                else stage_next = ST_SERIAL;
              end
              phase_next = PH_LEN1;
            end
          end
          PH_LEN1: begin
            if ((data_byte & LEN_LONG_MASK) != 8'd0) begin
              acc_next = '0;
              if (p_ext + {11'd0, cnt} + 18'd1 > reg_end) begin
                fail    = 1'b1;
                fail_id = fail_field(stage);
              end else if (cnt == 7'd0) begin
                hd = 1'b1;
              end else begin
                len_left_next = cnt;
                phase_next    = PH_LENX;
              end
            end else begin
              acc_next = {24'd0, data_byte};
              hd       = 1'b1;
            end
          end
          PH_LENX: begin
            acc_next      = {acc[ACC_W-9:0], data_byte};
            len_left_next = len_left - 7'd1;
            if (len_left_next == 7'd0) hd = 1'b1;
          end
          default: begin
            if (cs >= {1'b0, content_end}) phase_next = PH_TAG;
          end
        endcase
      end

      if (hd) begin
        room_left = reg_end - cs;
        if (acc_next > {14'd0, room_left}) begin
          fail    = 1'b1;
          fail_id = fail_field(stage);
        end else begin
          ce               = cs + acc_next[17:0];
          content_end_next = ce[POS_W-1:0];
          full             = ce - {2'd0, hdr_start};
          nxt              = ce;
          nreg             = {1'b0, body_end};
          case (stage)
            ST_OUTER: begin
              outer_end_next = ce[POS_W-1:0];
              stage_next     = ST_BODY;
              nxt            = cs;
              nreg           = ce;
            end
            ST_BODY: begin
              body_end_next = ce[POS_W-1:0];
              stage_next    = ST_FIRST;
              nxt           = cs;
              nreg          = ce;
            end
            ST_VERSION: stage_next = ST_SERIAL;
            ST_SERIAL: begin
              res0_valid    = 1'b1;
              res0.field_id = FID_SERIAL_HDR;
              res0.offset   = hdr_start;
              res0.length   = full[16:0];
              res1_valid    = 1'b1;
              res1.field_id = FID_SERIAL_VAL;
              res1.offset   = cs[15:0];
              res1.length   = acc_next[16:0];
              stage_next    = ST_OID;
            end
            ST_OID: stage_next = ST_ISSUER;
            ST_ISSUER: begin
              res0_valid    = 1'b1;
              res0.field_id = FID_ISSUER;
              res0.offset   = hdr_start;
              res0.length   = full[16:0];
              if (stop_after_issuer) begin
                res0.last     = 1'b1;
                finished_next = 1'b1;
              end else begin
                stage_next = ST_VALID;
              end
            end
            ST_VALID: begin
              res0_valid    = 1'b1;
              res0.field_id = FID_VALIDITY;
              res0.offset   = cs[15:0];
              res0.length   = acc_next[16:0];
              stage_next    = ST_SUBJ;
            end
            ST_SUBJ: begin
              res0_valid    = 1'b1;
              res0.field_id = FID_SUBJECT;
              res0.offset   = hdr_start;
              res0.length   = full[16:0];
              stage_next    = ST_KEY;
            end
            default: begin
              res0_valid    = 1'b1;
              res0.field_id = FID_KEY;
              res0.offset   = hdr_start;
              res0.length   = full[16:0];
              res0.last     = 1'b1;
              finished_next = 1'b1;
            end
          endcase
          if (!finished_next) begin
            if (nxt + 18'd2 > nreg) begin
              fail    = 1'b1;
              fail_id = fail_field(stage_next);
            end else if (nxt == cs) begin
              phase_next = PH_TAG;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end

      if (fail) begin
        res0_valid    = 1'b1;
        res0          = '0;
        res0.field_id = fail_id;
        res0.failed   = 1'b1;
        res0.last     = 1'b1;
        res1_valid    = 1'b0;
        finished_next = 1'b1;
      end
    end

    pos_inc  = p_ext + 18'd1;
    pos_next = pos_inc[POS_W-1:0];
    if (finished_next && pos_inc >= {1'b0, cert_end_next}) begin
      pos_next      = '0;
      stage_next    = ST_OUTER;
      phase_next    = PH_TAG;
      len_left_next = '0;
      acc_next      = '0;
      finished_next = 1'b0;
    end

    if (!step) begin
      res0_valid = 1'b0;
      res1_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      stage       <= ST_OUTER;
      phase       <= PH_TAG;
      len_left    <= '0;
      acc         <= '0;
      hdr_start   <= '0;
      content_end <= '0;
      outer_end   <= '0;
      body_end    <= '0;
      cert_end    <= '0;
      finished    <= 1'b0;
    end else if (step) begin
      pos         <= pos_next;
      stage       <= stage_next;
      phase       <= phase_next;
      len_left    <= len_left_next;
      acc         <= acc_next;
      hdr_start   <= hdr_start_next;
      content_end <= content_end_next;
      outer_end   <= outer_end_next;
      body_end    <= body_end_next;
      cert_end    <= cert_end_next;
      finished    <= finished_next;
    end
  end

endmodule

// ===== hw/rtl/xdfl_res_fifo.sv =====
module xdfl_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr0,
  input  xdfl_pkg::result_t din0,
  input  logic              wr1,
  input  xdfl_pkg::result_t din1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output xdfl_pkg::result_t dout
);
  import xdfl_pkg::*;

  result_t                entry [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wp, rp;
  logic [RES_CNT_W-1:0]   count, count_next;
  logic                   pop;
  logic [RES_PTR_W-1:0]   wp1;

  assign out_valid = (count != '0);
  assign dout      = entry[rp];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign wp1       = wp + RES_PTR_W'(1);

  always_comb begin
    count_next = count + RES_CNT_W'(wr0) + RES_CNT_W'(wr0 && wr1) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr0) entry[wp] <= din0;
    if (wr0 && wr1) entry[wp1] <= din1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) rp <= rp + RES_PTR_W'(1);
      if (wr0 && wr1) wp <= wp + RES_PTR_W'(2);
      else if (wr0) wp <= wp1;
    end
  end

endmodule

// ===== hw/rtl/x509_der_field_locator_top.sv =====
// path: an accepted byte is held in the input register, parsed by the core and its results
// written into the result queue; a second result (serial value) is queued with the first
// throughput: one byte per cycle; the parser core does one header step per byte
// and stalls input only while the four-entry result queue lacks room for two
// reset: rst is synchronous, active high; clears the parser, queue and register
module x509_der_field_locator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte[7:0], total_length[24:8], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // offset[15:0], length[32:16], zero pad
  output logic [3:0]  m_axis_tuser,  // field_id[2:0], failed[3]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data       // stop_after_issuer
);
  import xdfl_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [16:0] in_total;
  logic        stop_after_issuer;
  logic        room2;
  logic        step;
  logic        res0_valid, res1_valid;
  result_t     res0, res1, head;

  assign step          = in_valid && room2;
  assign s_axis_tready = !in_valid || room2;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata[7:0];
      in_total <= s_axis_tdata[24:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      stop_after_issuer <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (cfg_valid && cfg_ready) stop_after_issuer <= cfg_data;
    end
  end

  xdfl_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .data_byte         (in_byte),
    .total_length      (in_total),
    .stop_after_issuer (stop_after_issuer),
    .res0_valid        (res0_valid),
    .res0              (res0),
    .res1_valid        (res1_valid),
    .res1              (res1)
  );

  xdfl_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr0       (res0_valid),
    .din0      (res0),
    .wr1       (res1_valid),
    .din1      (res1),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (head)
  );

  assign m_axis_tdata = {7'd0, head.length, head.offset};
  assign m_axis_tuser = {head.failed, head.field_id};
  assign m_axis_tlast = head.last;

endmodule

// ===== verif/tb_x509_der_field_locator_top.sv =====
`timescale 1ns / 100ps

module tb_x509_der_field_locator_top;
  import xdfl_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_BYTES = 150;
  localparam int DIR_ROWS = 29;
  localparam result_t ABORT_AT_START = '{
    field_id: FID_SERIAL_HDR, offset: 16'd0, length: 17'd0, failed: 1'b1, last: 1'b1
  };

  typedef logic [7:0] bytes_t[$];
  typedef enum {ROW_PREDICT, ROW_QUIET, ROW_ABORT} row_kind_t;
  typedef struct {
    logic [7:0]  data_byte;
    logic [16:0] total;
    int unsigned reps;
    row_kind_t   kind;
  } stim_row_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_WINDOW, RX_COIN} rx_pattern_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  x509_der_field_locator_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // locator tracking state
  logic        cfg_stop;
  int unsigned trk_pos;
  stage_t      trk_stage;
  phase_t      trk_phase;
  int unsigned trk_len_left;
  int unsigned trk_acc;
  int unsigned trk_hdr_start;
  int unsigned trk_content_end;
  int unsigned trk_outer_end;
  int unsigned trk_body_end;
  int unsigned trk_cert_end;
  bit          trk_done;
  bit          trk_mute;

  result_t     step_out[$];
  result_t     located_q[$];
  result_t     seen_r;
  result_t     want_r;
  int          mismatches = 0;
  int unsigned idle_cycles = 0;
  int          burst_left = 0;
  bytes_t      cert_q;
  int unsigned cert_total;
  logic [7:0]  rx_tick = '0;
  rx_pattern_t rx_mode = RX_OPEN;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h30, 17'd1,      1,     ROW_ABORT},   // total below two
    '{8'hff, 17'd0,      1,     ROW_ABORT},
    '{8'h00, 17'd2,      1,     ROW_ABORT},   // zero tag
    '{8'hff, 17'h15555,  1,     ROW_QUIET},
    '{8'h30, 17'd3,      1,     ROW_QUIET},
    '{8'h82, 17'h0aaaa,  1,     ROW_ABORT},   // length bytes overrun
    '{8'h00, 17'd0,      1,     ROW_QUIET},
    '{8'h30, 17'd4,      1,     ROW_QUIET},
    '{8'h03, 17'd0,      1,     ROW_ABORT},   // length overruns region
    '{8'h00, 17'd0,      2,     ROW_QUIET},
    '{8'h30, 17'd3,      1,     ROW_QUIET},
    '{8'h01, 17'd0,      1,     ROW_ABORT},   // no room for body header
    '{8'h7f, 17'd0,      1,     ROW_QUIET},
    '{8'h30, 17'd16,     1,     ROW_PREDICT}, // long form lengths
    '{8'h82, 17'd0,      1,     ROW_PREDICT},
    '{8'h00, 17'd0,      1,     ROW_PREDICT},
    '{8'h0c, 17'd0,      1,     ROW_PREDICT},
    '{8'h30, 17'd0,      1,     ROW_PREDICT},
    '{8'h85, 17'd0,      1,     ROW_PREDICT},
    '{8'h12, 17'd0,      1,     ROW_PREDICT}, // wraps out of the accumulator
    '{8'h00, 17'd0,      3,     ROW_PREDICT},
    '{8'h05, 17'd0,      1,     ROW_PREDICT},
    '{8'h02, 17'd0,      1,     ROW_PREDICT},
    '{8'h01, 17'd0,      1,     ROW_PREDICT},
    '{8'h55, 17'd0,      1,     ROW_PREDICT},
    '{8'h06, 17'd0,      1,     ROW_PREDICT},
    '{8'h00, 17'd0,      1,     ROW_PREDICT},
    '{8'h30, 17'd2,      1,     ROW_QUIET},
    '{8'h80, 17'd0,      1,     ROW_ABORT}    // indefinite length
  };

  function automatic void clear_tracker();
    trk_pos = 0;
    trk_stage = ST_OUTER;
    trk_phase = PH_TAG;
    trk_len_left = 0;
    trk_acc = 0;
    trk_done = 1'b0;
  endfunction

  function automatic int unsigned region_limit();
    if (trk_stage == ST_OUTER) return trk_cert_end;
    if (trk_stage == ST_BODY) return trk_outer_end;
    return trk_body_end;
  endfunction

  function automatic logic [2:0] failing_field();
    if (trk_stage <= ST_SERIAL) return FID_SERIAL_HDR;
    if (trk_stage <= ST_ISSUER) return FID_ISSUER;
    if (trk_stage == ST_VALID) return FID_VALIDITY;
    if (trk_stage == ST_SUBJ) return FID_SUBJECT;
    return FID_KEY;
  endfunction

  function automatic void stage_field(input logic [2:0] id, input int unsigned off,
                                      input int unsigned len, input logic failed,
                                      input logic last);
    result_t r;
    r.field_id = id;
    r.offset = off[15:0];
    r.length = len[16:0];
    r.failed = failed;
    r.last = last;
    step_out.push_back(r);
  endfunction

  // a failure replaces anything staged in the same byte
  function automatic void abort_cert();
    step_out.delete();
    stage_field(failing_field(), 0, 0, 1'b1, 1'b1);
    trk_done = 1'b1;
  endfunction

  function automatic void close_header(input int unsigned p);
    int unsigned cs;
    int unsigned full;
    int unsigned nxt;
    int unsigned nlim;
    cs = p + 1;
    if (trk_acc > region_limit() - cs) begin
      abort_cert();
      return;
    end
    trk_content_end = cs + trk_acc;
    full = trk_content_end - trk_hdr_start;
    nxt = trk_content_end;
    nlim = trk_body_end;
    case (trk_stage)
      ST_OUTER: begin
        trk_outer_end = trk_content_end;
        trk_stage = ST_BODY;
        nxt = cs;
        nlim = trk_outer_end;
      end
      ST_BODY: begin
        trk_body_end = trk_content_end;
        trk_stage = ST_FIRST;
        nxt = cs;
        nlim = trk_body_end;
      end
      ST_VERSION: trk_stage = ST_SERIAL;
      ST_SERIAL: begin
        stage_field(FID_SERIAL_HDR, trk_hdr_start, full, 1'b0, 1'b0);
        stage_field(FID_SERIAL_VAL, cs, trk_acc, 1'b0, 1'b0);
        trk_stage = ST_OID;
      end
      ST_OID: trk_stage = ST_ISSUER;
      ST_ISSUER: begin
        if (cfg_stop) begin
          stage_field(FID_ISSUER, trk_hdr_start, full, 1'b0, 1'b1);
          trk_done = 1'b1;
          return;
        end
        stage_field(FID_ISSUER, trk_hdr_start, full, 1'b0, 1'b0);
        trk_stage = ST_VALID;
      end
      ST_VALID: begin
        stage_field(FID_VALIDITY, cs, trk_acc, 1'b0, 1'b0);
        trk_stage = ST_SUBJ;
      end
      ST_SUBJ: begin
        stage_field(FID_SUBJECT, trk_hdr_start, full, 1'b0, 1'b0);
        trk_stage = ST_KEY;
      end
      default: begin
        stage_field(FID_KEY, trk_hdr_start, full, 1'b0, 1'b1);
        trk_done = 1'b1;
        return;
      end
    endcase
    if (nxt + 2 > nlim) begin
      abort_cert();
      return;
    end
    trk_phase = (nxt == cs) ? PH_TAG : PH_SKIP;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic [16:0] tl);
    int unsigned p;
    int unsigned cnt;
    p = trk_pos;
    step_out.delete();
    if (!trk_done) begin
      if (p == 0) trk_cert_end = (tl > MAX_CERT_BYTES) ? MAX_CERT_BYTES : 32'(tl);
      if (p == 0 && trk_cert_end < 2) begin
        abort_cert();
      end else if (trk_phase == PH_TAG) begin
        trk_hdr_start = p;
        if (b == 8'h00) begin
          abort_cert();
        end else begin
          if (trk_stage == ST_FIRST)
            trk_stage = ((b & VERSION_TAG_MASK) == VERSION_TAG_MASK) ? ST_VERSION : ST_SERIAL;
          trk_phase = PH_LEN1;
        end
      end else if (trk_phase == PH_LEN1) begin
        if ((b & LEN_LONG_MASK) != 0) begin
          cnt = 32'(b[6:0] & LEN_CNT_MASK);
          trk_acc = 0;
          if (p + cnt + 1 > region_limit()) begin
            abort_cert();
          end else if (cnt == 0) begin
            close_header(p);
          end else begin
            trk_len_left = cnt;
            trk_phase = PH_LENX;
          end
        end else begin
          trk_acc = 32'(b);
          close_header(p);
        end
      end else if (trk_phase == PH_LENX) begin
        trk_acc = (trk_acc << 8) | 32'(b);
        trk_len_left = trk_len_left - 1;
        if (trk_len_left == 0) close_header(p);
      end else if (p + 1 >= trk_content_end) begin
        trk_phase = PH_TAG;
      end
    end
    trk_pos = p + 1;
    if (trk_done && trk_pos >= trk_cert_end) clear_tracker();
    if (!trk_mute) foreach (step_out[i]) located_q.push_back(step_out[i]);
  endfunction

  // certificate building
  function automatic bytes_t len_field(input int unsigned n);
    bytes_t h;
    int unsigned form;
    form = $urandom_range(0, 9);
    if (n == 0 && form == 0) h = {LEN_LONG_MASK};
    else if (n < 128 && form < 6) h = {n[7:0]};
    else if (n < 256 && form < 8) h = {8'h81, n[7:0]};
    else if (form == 8) h = {8'h82, n[15:8], n[7:0]};
    else h = {8'h85, 8'($urandom), n[31:24], n[23:16], n[15:8], n[7:0]};
    return h;
  endfunction

  function automatic bytes_t tlv(input logic [7:0] tag, input bytes_t content);
    bytes_t r;
    r = len_field(content.size());
    r.push_front(tag);
    return {r, content};
  endfunction

  function automatic bytes_t filler(input int unsigned max_n);
    bytes_t r;
    int unsigned n;
    n = $urandom_range(0, max_n);
    repeat (n) r.push_back(8'($urandom));
    return r;
  endfunction

  function automatic logic [7:0] plain_tag();
    logic [7:0] t;
    t = 8'($urandom_range(1, 255));
    if ((t & VERSION_TAG_MASK) == VERSION_TAG_MASK) t = t & 8'h5f;
    if (t == 8'h00) t = 8'h02;
    return t;
  endfunction

  function automatic void build_cert();
    bytes_t body;
    bytes_t outer;
    int unsigned idx;
    body = {};
    if ($urandom_range(0, 2) != 0)
      body = tlv(VERSION_TAG_MASK | (8'($urandom) & 8'h5f), filler(3));
    // serial, algorithm, issuer, validity, subject, key info
    repeat (6) body = {body, tlv(plain_tag(), filler(5))};
    if ($urandom_range(0, 3) == 0) body = {body, tlv(plain_tag(), filler(3))};
    outer = {tlv(8'h30, body), filler(6)};
    cert_q = {tlv(8'h30, outer), filler(3)};
    case ($urandom_range(0, 11))
      0: begin
        idx = $urandom_range(0, cert_q.size() - 1);
        cert_q[idx] = 8'($urandom);
      end
      1: begin
        idx = $urandom_range(0, cert_q.size() - 1);
        cert_q = cert_q[0:idx];
      end
      2: begin
        idx = $urandom_range(0, 12);
        cert_q[idx] = 8'h00;
      end
      3: begin
        cert_q = filler(24);
        if (cert_q.size() == 0) cert_q.push_back(8'h30);
      end
      default: ;
    endcase
    cert_total = cert_q.size();
  endfunction

  // stimulus driving
  task automatic send_byte(input logic [7:0] b, input logic [16:0] tl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tdata <= {7'd0, tl, b};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    track_byte(b, tl);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (located_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_stop(input logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_stop = v;
  endtask

  function automatic void log_mismatch(input string what, input result_t want,
                                       input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected id %0d off %0d len %0d failed %0b last %0b, %s",
               what, want.field_id, want.offset, want.length, want.failed, want.last,
               $sformatf("got id %0d off %0d len %0d failed %0b last %0b",
                         got.field_id, got.offset, got.length, got.failed, got.last));
  endfunction

  // result checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_r.field_id = m_axis_tuser[2:0];
      seen_r.offset = m_axis_tdata[15:0];
      seen_r.length = m_axis_tdata[32:16];
      seen_r.failed = m_axis_tuser[3];
      seen_r.last = m_axis_tlast;
      if (located_q.size() == 0) begin
        log_mismatch("unexpected", '0, seen_r);
      end else begin
        want_r = located_q.pop_front();
        if (want_r !== seen_r) log_mismatch("field", want_r, seen_r);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= rx_pattern_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_WINDOW: m_axis_tready <= (rx_tick[3:0] < 4'd5);
        default:   m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    cfg_stop = 1'b0;
    trk_mute = 1'b0;
    trk_hdr_start = 0;
    trk_content_end = 0;
    trk_outer_end = 0;
    trk_body_end = 0;
    trk_cert_end = 0;
    clear_tracker();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_stop(1'b0);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        trk_mute = (dir_rows[r].kind != ROW_PREDICT);
        send_byte(dir_rows[r].data_byte, dir_rows[r].total);
        if (dir_rows[r].kind == ROW_ABORT) located_q.push_back(ABORT_AT_START);
      end
    end
    trk_mute = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      write_stop(ph != 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_cert();
        foreach (cert_q[i])
          send_byte(cert_q[i], (i == 0) ? 17'(cert_total) : 17'($urandom));
        sent += cert_q.size();
      end
    end
    settle();

    if (mismatches == 0 && located_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
